[hdl/decimal_text_to_fixed_parser_core_assert.svh]
// Assertion macros for the decimal text parser core.
// Users must have clk and arst_n in scope; bodies vanish when SYNTH is set.
`ifndef DECIMAL_TEXT_TO_FIXED_PARSER_CORE_ASSERT_SVH
`define DECIMAL_TEXT_TO_FIXED_PARSER_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define DTFP_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// next-cycle implication
`define DTFP_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define DTFP_ASSERT_IMP(lbl, ante, cons, msg)
`define DTFP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/dtfp_pkg.sv]
// Shared types, codes and constants of the decimal text parser.
// No dependencies.
package dtfp_pkg;

	// parameter defaults
	localparam int MAX_CHARS_DEF = 256;
	localparam int FRAC_BITS_DEF = 24;

	// fixed widths
	localparam int LEN_W  = 9;
	localparam int ADDR_W = 3;
	localparam int FIDX_W = 4;

	// register map (index = paddr[2])
	localparam logic REG_NUMBER_TYPE = 1'b0;

	// number type register: bit 0 unsigned, bit 1 real
	localparam int NT_UNSIGNED_BIT = 0;
	localparam int NT_REAL_BIT     = 1;
	localparam logic [1:0] NT_RESET = 2'd2;

	// characters
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	// fraction digit index stops here (scale is zero from this digit on)
	localparam logic [FIDX_W-1:0] FIDX_MAX = 4'd9;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_INT,
		PH_DOT,
		PH_FRAC
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NO_DIGITS,
		ST_MINUS_UNSIGNED,
		ST_FRAC_ON_INT
	} status_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       start_req;
	} char_beat_t;

	typedef struct packed {
		status_t            status;
		logic signed [63:0] value;
		logic [LEN_W-1:0]   length;
	} result_beat_t;

	// parse state apart from the integer accumulator
	typedef struct packed {
		phase_t             phase;
		logic               neg;
		logic [31:0]        fsum;
		logic [FIDX_W-1:0]  fidx;
		logic [LEN_W-1:0]   consumed;
		logic               seen;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase: PH_IDLE, neg: 1'b0, fsum: 32'd0, fidx: '0, consumed: '0, seen: 1'b0
	};
	localparam state_t STATE_START = '{
		phase: PH_INT, neg: 1'b0, fsum: 32'd0, fidx: '0, consumed: '0, seen: 1'b0
	};

	// Q0.32 weight of the fraction digit at position idx (0 = first digit)
	function automatic logic [31:0] frac_scale(input logic [FIDX_W-1:0] idx);
		case (idx)
			4'd0:    return 32'h1999999A;
			4'd1:    return 32'h028F5C29;
			4'd2:    return 32'h00418937;
			4'd3:    return 32'h00068DB8;
			4'd4:    return 32'h0000A7C5;
			4'd5:    return 32'h000010C6;
			4'd6:    return 32'h000001AD;
			4'd7:    return 32'h0000002A;
			4'd8:    return 32'h00000004;
			default: return 32'h00000000;
		endcase
	endfunction

endpackage

[hdl/dtfp_stream_if.sv]
// Valid/ready stream channel carrying one payload beat.
// Payload type is set per instance; no package dependency.
interface dtfp_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[hdl/dtfp_step.sv]
// Next-state and result logic for one character of the parser.
// Depends on dtfp_pkg.
module dtfp_step #(
	parameter int MAX_CHARS = dtfp_pkg::MAX_CHARS_DEF,
	parameter int FRAC_BITS = dtfp_pkg::FRAC_BITS_DEF
) (
	input  dtfp_pkg::state_t       st,
	input  logic [62-FRAC_BITS:0]  acc,
	input  dtfp_pkg::char_beat_t   beat,
	input  logic [1:0]             ntype,
	output dtfp_pkg::state_t       st_nxt,
	output logic [62-FRAC_BITS:0]  acc_nxt,
	output logic                   res_vld,
	output dtfp_pkg::result_beat_t res
);
	import dtfp_pkg::*;

	localparam int IW      = 63 - FRAC_BITS;
	localparam int LEN_LIM = (MAX_CHARS < 511) ? MAX_CHARS : 511;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LEN_LIM);
	localparam logic [IW-1:0]    IMAX    = '1;

	state_t            cur;
	logic [IW-1:0]     acc_cur;
	logic              is_digit;
	logic              is_dot;
	logic              is_minus;
	logic              is_plus;
	logic [3:0]        dval;
	logic [IW+3:0]     acc_mul;
	logic [IW-1:0]     acc_sat;
	logic [31:0]       scale;
	logic [35:0]       frac_prod;
	logic [36:0]       frac_wide;
	logic [31:0]       frac_sat;
	logic [FIDX_W-1:0] fidx_inc;
	logic [LEN_W:0]    cnt1;
	logic [LEN_W:0]    cnt2;
	logic [LEN_W-1:0]  cons1;
	logic [LEN_W-1:0]  cons2;
	logic [63:0]       mag;
	logic              emit;
	status_t           code;

	// a start beat begins from a cleared state
	assign cur     = beat.start_req ? STATE_START : st;
	assign acc_cur = beat.start_req ? '0 : acc;

	// character classes
	assign is_digit = beat.char_code inside {[CH_ZERO:CH_NINE]};
	assign is_dot   = (beat.char_code == CH_DOT);
	assign is_minus = (beat.char_code == CH_MINUS);
	assign is_plus  = (beat.char_code == CH_PLUS);
	assign dval     = beat.char_code[3:0];

	// integer digit: acc*10 + d, saturating
	assign acc_mul = (IW+4)'({acc_cur, 3'b000}) + (IW+4)'({acc_cur, 1'b0}) + (IW+4)'(dval);
	assign acc_sat = (acc_mul > (IW+4)'(IMAX)) ? IMAX : acc_mul[IW-1:0];

	// fraction digit: sum += d * scale_k, clamped to 32 bits
	assign scale     = frac_scale(cur.fidx);
	assign frac_prod = 36'(scale) * 36'(dval);
	assign frac_wide = 37'(cur.fsum) + 37'(frac_prod);
	assign frac_sat  = (frac_wide[36:32] != '0) ? '1 : frac_wide[31:0];
	assign fidx_inc  = (cur.fidx == FIDX_MAX) ? cur.fidx : cur.fidx + 1'b1;

	// consumed length, saturating
	assign cnt1  = {1'b0, cur.consumed} + (LEN_W+1)'(1);
	assign cnt2  = {1'b0, cur.consumed} + (LEN_W+1)'(2);
	assign cons1 = (cnt1 > {1'b0, LEN_MAX}) ? LEN_MAX : cnt1[LEN_W-1:0];
	assign cons2 = (cnt2 > {1'b0, LEN_MAX}) ? LEN_MAX : cnt2[LEN_W-1:0];

	// parse step
	always_comb begin
		st_nxt  = cur;
		acc_nxt = acc_cur;
		emit    = 1'b0;
		code    = ST_OK;
		if (beat.start_req && (is_plus || is_minus)) begin
			if (is_minus && ntype[NT_UNSIGNED_BIT]) begin
				emit = 1'b1;
				code = ST_MINUS_UNSIGNED;
			end else begin
				st_nxt.neg      = is_minus;
				st_nxt.consumed = LEN_W'(1);
			end
		end else begin
			case (cur.phase)
				PH_INT: begin
					if (is_digit) begin
						acc_nxt         = acc_sat;
						st_nxt.seen     = 1'b1;
						st_nxt.consumed = cons1;
					end else if (is_dot) begin
						st_nxt.phase = PH_DOT;
					end else begin
						emit = 1'b1;
						code = cur.seen ? ST_OK : ST_NO_DIGITS;
					end
				end
				PH_DOT: begin
					if (is_digit) begin
						if (!ntype[NT_REAL_BIT]) begin
							emit = 1'b1;
							code = ST_FRAC_ON_INT;
						end else begin
							st_nxt.fsum     = frac_sat;
							st_nxt.fidx     = fidx_inc;
							st_nxt.seen     = 1'b1;
							st_nxt.consumed = cons2;
							st_nxt.phase    = PH_FRAC;
						end
					end else begin
						emit = 1'b1;
						code = cur.seen ? ST_OK : ST_NO_DIGITS;
					end
				end
				PH_FRAC: begin
					if (is_digit) begin
						st_nxt.fsum     = frac_sat;
						st_nxt.fidx     = fidx_inc;
						st_nxt.consumed = cons1;
					end else begin
						emit = 1'b1;
						code = ST_OK;
					end
				end
				default: begin
				end
			endcase
		end
		if (emit) begin
			st_nxt.phase = PH_IDLE;
		end
	end

	// result beat: magnitude is integer part over the top fraction bits
	assign mag     = {1'b0, acc_cur, cur.fsum[31 -: FRAC_BITS]};
	assign res_vld = emit;

	always_comb begin
		res.status = code;
		res.value  = 64'sd0;
		res.length = '0;
		if (code == ST_OK) begin
			res.value  = cur.neg ? $signed(~mag + 64'd1) : $signed(mag);
			res.length = cur.consumed;
		end
	end

endmodule

[hdl/decimal_text_to_fixed_parser_core.sv]
// Decimal text to signed fixed-point parser, top level; uses dtfp_pkg, dtfp_stream_if, dtfp_step.
// A character is captured in the input register, and its result beat then in the result register.
// Throughput: one character per cycle unless res_out stalls; the parse state updates through a single
// register loop (multiply-by-ten add and fraction weight add) in dtfp_step.
// Reset (arst_n low, async): parser idle, number_type = signed real, no beats pending.
`include "decimal_text_to_fixed_parser_core_assert.svh"
module decimal_text_to_fixed_parser_core #(
	parameter int MAX_CHARS = dtfp_pkg::MAX_CHARS_DEF,
	parameter int FRAC_BITS = dtfp_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dtfp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	dtfp_stream_if.sink                 char_in,
	dtfp_stream_if.source               res_out
);
	import dtfp_pkg::*;

	localparam int IW      = 63 - FRAC_BITS;
	localparam int LEN_LIM = (MAX_CHARS < 511) ? MAX_CHARS : 511;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LEN_LIM);

	logic [1:0]     number_type_q;
	logic           valid_s1;
	char_beat_t     char_s1;
	state_t         st_q;
	logic [IW-1:0]  acc_q;
	state_t         st_nxt;
	logic [IW-1:0]  acc_nxt;
	logic           res_vld;
	result_beat_t   res;
	logic           out_valid_q;
	result_beat_t   res_q;
	logic           adv;
	logic           cfg_wr;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_NUMBER_TYPE);
	assign prdata = (paddr[ADDR_W-1:2] == REG_NUMBER_TYPE) ? {30'd0, number_type_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_type_q <= NT_RESET;
		end else if (cfg_wr) begin
			number_type_q <= pwdata[1:0];
		end
	end

	// flow control: stage 2 moves when the result register is free or draining
	assign adv           = !out_valid_q || res_out.ready;
	assign char_in.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.ready) begin
			char_s1 <= char_in.payload;
		end
	end

	// per-character parse step
	dtfp_step #(
		.MAX_CHARS(MAX_CHARS),
		.FRAC_BITS(FRAC_BITS)
	) u_step (
		.st      (st_q),
		.acc     (acc_q),
		.beat    (char_s1),
		.ntype   (number_type_q),
		.st_nxt  (st_nxt),
		.acc_nxt (acc_nxt),
		.res_vld (res_vld),
		.res     (res)
	);

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= STATE_RESET;
			acc_q <= '0;
		end else if (valid_s1 && adv) begin
			st_q  <= st_nxt;
			acc_q <= acc_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res_vld) begin
			res_q <= res;
		end
	end

	assign res_out.valid   = out_valid_q;
	assign res_out.payload = res_q;

	// checks
	`DTFP_ASSERT_IMP(a_fail_zero, res_out.valid && res_out.payload.status != ST_OK, res_out.payload.value == 64'sd0 && res_out.payload.length == '0, "failed parse carries nonzero value or length")
	`DTFP_ASSERT_IMP(a_len_lim, res_out.valid, res_out.payload.length <= LEN_MAX, "length beyond limit")
	`DTFP_ASSERT_NXT(a_idle_after_res, valid_s1 && adv && res_vld, st_q.phase == PH_IDLE, "parser not idle after result")
	`DTFP_ASSERT_NXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(char_s1), "input stage lost a held beat")
	`DTFP_ASSERT_IMP(a_fidx_range, 1'b1, st_q.fidx <= FIDX_MAX, "fraction digit index out of range")

endmodule
